>>> rtl/nps_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nps_pkg
// Shared widths and types for the next-prime search block.
// ---------------------------------------------------------------------------
package nps_pkg;

  localparam int VAL_W  = 32;          // start value and result width
  localparam int CAND_W = VAL_W + 1;   // candidate may step past 2^32-1
  localparam int DVSR_W = 17;          // odd divisors up to 2^16+1
  localparam int SQ_W   = 2 * DVSR_W + 1;
  localparam int CNT_W  = $clog2(VAL_W + 1);

  typedef struct packed {
    logic              go;
    logic [VAL_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } nps_mod_req_t;

  typedef struct packed {
    logic              done;
    logic [DVSR_W-1:0] rem;
  } nps_mod_rsp_t;

endpackage
`default_nettype wire

>>> rtl/nps_mod_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nps_mod_unit
// Restoring remainder unit: one dividend bit per cycle, done pulse at end.
// ---------------------------------------------------------------------------
module nps_mod_unit (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire nps_pkg::nps_mod_req_t req,
  output nps_pkg::nps_mod_rsp_t      rsp
);
  import nps_pkg::*;

  logic              active_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [VAL_W-1:0]  dvd_r;
  logic [DVSR_W-1:0] dvsr_r;
  logic [DVSR_W-1:0] rem_r;
  logic [DVSR_W:0]   shifted;
  logic [DVSR_W:0]   diff;
  logic [DVSR_W-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, dvd_r[VAL_W-1]};
    diff    = shifted - {1'b0, dvsr_r};
    if (shifted >= {1'b0, dvsr_r}) begin
      rem_nxt = diff[DVSR_W-1:0];
    end else begin
      rem_nxt = shifted[DVSR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        active_r <= 1'b1;
        cnt_r    <= CNT_W'(VAL_W);
        dvd_r    <= req.dividend;
        dvsr_r   <= req.divisor;
        rem_r    <= '0;
      end else if (active_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[VAL_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

>>> rtl/next_prime_search.sv
`default_nettype none
// ---------------------------------------------------------------------------
// next_prime_search
// Smallest prime not below a start value, by trial division with odd
// divisors while divisor squared does not exceed the candidate.
// ---------------------------------------------------------------------------
// channel   ports                                   handshake
// input     in_start_value                          start & !busy
// result    out_prime_value, out_overflow           out_valid, one cycle
//
// Each divisor tried takes a square compare in S_TEST and then a pass of
// the bit-serial remainder unit in S_DIV, which sets the rate. A 32-bit
// candidate needs up to 32767 divisors; the total depends on the prime gap.
// busy stays high from acceptance to the result; reset is synchronous,
// active low, and returns the sequencer to idle. Results cannot be stalled.
// ---------------------------------------------------------------------------
module next_prime_search #(
  parameter int WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [31:0] in_start_value,
  output logic        out_valid,
  output logic [31:0] out_prime_value,
  output logic        out_overflow
);
  import nps_pkg::*;

  localparam int LIM_BITS = (WIDTH < VAL_W) ? WIDTH : VAL_W;
  localparam logic [CAND_W-1:0] LIMIT = (CAND_W'(1) << LIM_BITS) - CAND_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_TEST, S_DIV} state_t;

  state_t            state_r,  state_nxt;
  logic [CAND_W-1:0] cand_r,   cand_nxt;
  logic [DVSR_W-1:0] div_r,    div_nxt;
  logic [SQ_W-1:0]   sq_r,     sq_nxt;
  logic              vld_r,    vld_nxt;
  logic [VAL_W-1:0]  prime_r,  prime_nxt;
  logic              ovf_r,    ovf_nxt;
  nps_mod_req_t      mreq;
  nps_mod_rsp_t      mrsp;

  nps_mod_unit u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .rsp  (mrsp)
  );

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    vld_nxt       = 1'b0;
    prime_nxt     = prime_r;
    ovf_nxt       = ovf_r;
    mreq.go       = 1'b0;
    mreq.dividend = cand_r[VAL_W-1:0];
    mreq.divisor  = div_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_start_value <= 32'd2) begin
            cand_nxt = CAND_W'(2);
          end else begin
            cand_nxt = {1'b0, in_start_value | 32'd1};
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cand_r == CAND_W'(2)) begin
          vld_nxt   = 1'b1;
          prime_nxt = VAL_W'(2);
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else if (cand_r > LIMIT) begin
          vld_nxt   = 1'b1;
          prime_nxt = '0;
          ovf_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          div_nxt   = DVSR_W'(3);
          sq_nxt    = SQ_W'(9);
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (sq_r > SQ_W'(cand_r)) begin
          vld_nxt   = 1'b1;
          prime_nxt = cand_r[VAL_W-1:0];
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          mreq.go   = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (mrsp.done) begin
          if (mrsp.rem == '0) begin
            cand_nxt  = cand_r + CAND_W'(2);
            state_nxt = S_CHECK;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            div_nxt   = div_r + DVSR_W'(2);
            sq_nxt    = sq_r + SQ_W'({div_r, 2'b00}) + SQ_W'(4);
            state_nxt = S_TEST;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    cand_r  <= cand_nxt;
    div_r   <= div_nxt;
    sq_r    <= sq_nxt;
    prime_r <= prime_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = vld_r;
  assign out_prime_value = prime_r;
  assign out_overflow    = ovf_r;

endmodule
`default_nettype wire

>>> rtl/nps_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nps_checker
// Port-level checks on the next-prime search block, bound to the top level.
// ---------------------------------------------------------------------------
module nps_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire [31:0] in_start_value,
  input wire        out_valid,
  input wire [31:0] out_prime_value,
  input wire        out_overflow
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result word not at end of busy");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_prime_value == 32'd0)
    else $error("overflow word with nonzero prime");

  a_prime_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |-> out_prime_value[0] || out_prime_value == 32'd2)
    else $error("even result other than two");

  a_small_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_start_value <= 32'd2 |=> ##1
      out_valid && !out_overflow && out_prime_value == 32'd2)
    else $error("small start word did not give two");

endmodule

bind next_prime_search nps_checker u_nps_checker (.*);
`default_nettype wire

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// next_prime_search testbench
// Sends start words to the prime search block and checks each returned prime
// and overflow flag against a trial-division predictor in a small
// scoreboard. Directed words cover starts below two, prime squares, wide
// prime gaps and the no-prime-fits end of the range. They are followed by
// mostly narrow random words, so the long searches stay rare.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH        = 32;
  localparam int BOUND_BITS   = (WIDTH < 32) ? WIDTH : 32;
  localparam int RANDOM_WORDS = 76;
  localparam int CALM_WORDS   = 20;
  localparam int DRAIN_CYCLES = 80;
  localparam int N_DIRECTED   = 24;
  localparam longint unsigned CYCLE_LIMIT = 64'd16_000_000;

  typedef struct packed {
    logic [31:0] prime_value;
    logic        overflow;
  } prime_word_t;

  class prime_scoreboard;
    prime_word_t expected_q[$];
    int unsigned mismatches = 0;

    function prime_word_t smallest_prime_from(logic [31:0] from);
      longint unsigned bound, cand, dv;
      bit no_factor;
      prime_word_t res;
      res = '0;
      bound = (64'd1 << BOUND_BITS) - 64'd1;
      if (from <= 32'd2) begin
        if (bound >= 64'd2) res.prime_value = 32'd2;
        else res.overflow = 1'b1;
        return res;
      end
      cand = {32'd0, from} | 64'd1;
      while (cand <= bound) begin
        no_factor = 1'b1;
        for (dv = 64'd3; dv * dv <= cand; dv += 64'd2) begin
          if (cand % dv == 64'd0) begin
            no_factor = 1'b0;
            break;
          end
        end
        if (no_factor) begin
          res.prime_value = cand[31:0];
          return res;
        end
        cand += 64'd2;
      end
      res.overflow = 1'b1;
      return res;
    endfunction

    function void note_start(logic [31:0] from);
      expected_q = {expected_q, smallest_prime_from(from)};
    endfunction

    function void check_result(logic [31:0] prime_value, logic overflow);
      prime_word_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: prime %0d overflow %0b", prime_value, overflow);
        return;
      end
      want = expected_q.pop_front();
      if (prime_value !== want.prime_value || overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected prime %0d overflow %0b, got prime %0d overflow %0b",
                   want.prime_value, want.overflow, prime_value, overflow);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_start_value = 32'd0;
  logic        busy;
  logic        out_valid;
  logic [31:0] out_prime_value;
  logic        out_overflow;

  longint unsigned cycle_count = 64'd0;
  prime_scoreboard primes_sb;

  logic [31:0] directed_starts [N_DIRECTED] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9,
    32'd24, 32'd25, 32'd89, 32'd113, 32'd120, 32'd121, 32'd168, 32'd961,
    32'd1327, 32'd65521, 32'd65535, 32'd65536, 32'd1048576,
    32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  next_prime_search #(.WIDTH(WIDTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_start_value  (in_start_value),
    .out_valid       (out_valid),
    .out_prime_value (out_prime_value),
    .out_overflow    (out_overflow)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 64'd1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) primes_sb.check_result(out_prime_value, out_overflow);
  end

  // mostly narrow words, so the long searches stay rare
  function automatic logic [31:0] random_start();
    int unsigned w;
    logic [31:0] mask;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
    mask = (32'd1 << w) - 32'd1;
    return $urandom & mask;
  endfunction

  task automatic send_word(input logic [31:0] value);
    start <= 1'b1;
    in_start_value <= value;
    do @(posedge clk); while (busy);
    primes_sb.note_start(value);
  endtask

  task automatic maybe_pause(input bit calm);
    if (!calm && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin
    int k;
    primes_sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < N_DIRECTED; k++) begin
      send_word(directed_starts[k]);
      maybe_pause(1'b0);
    end
    for (k = 0; k < RANDOM_WORDS; k++) begin
      send_word(random_start());
      maybe_pause(k >= RANDOM_WORDS - CALM_WORDS);
    end
    start <= 1'b0;

    while (primes_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (primes_sb.mismatches == 0 && primes_sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/nps_pkg.sv
rtl/nps_mod_unit.sv
rtl/next_prime_search.sv
rtl/nps_checker.sv
tb/testbench.sv
